>>> hdl/uart_line_assembler_unit_defines.svh
// Assertion macros shared by the line assembler RTL.
`ifndef UART_LINE_ASSEMBLER_UNIT_DEFINES_SVH
`define UART_LINE_ASSEMBLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ULA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ULA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/ula_pkg.sv
// Types and constants of the UART line assembler.
package ula_pkg;

	localparam int LINE_STORE_DEPTH_DEF = 32;
	localparam int BYTE_W               = 8;
	localparam int LEN_W                = 6;
	localparam int ACT_LEN_W            = 5;
	localparam logic [ACT_LEN_W-1:0] ACT_LEN_RESET = 5'd14;

	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_CTRLZ = 8'd26;
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;

	typedef enum logic [1:0] {
		FUNC_RX_BYTE   = 2'd0,
		FUNC_READ_LINE = 2'd1,
		FUNC_CLR_LINE  = 2'd2,
		FUNC_CLR_ACT   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_LINE   = 2'd1,
		KIND_ACT    = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_ZTERM  = 4'b0010,
		ST_EMIT   = 4'b0100,
		ST_STATUS = 4'b1000
	} state_t;

	typedef struct packed {
		logic                  activation_ready;
		logic                  line_ready;
		logic [LEN_W-1:0]      length;
		logic                  last;
		logic [BYTE_W-1:0]     data_byte;
		kind_t                 kind;
	} result_t;

endpackage

>>> hdl/ula_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module ula_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/ula_obuf.sv
// Output register of the result stream.
module ula_obuf
	import ula_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ld,
	input  result_t     beat,
	output logic        free,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // data_byte[7:0], length[13:8], line_ready, activation_ready
	output logic [1:0]  m_tuser,  // kind
	output logic        m_tlast
);

	logic    valid_q;
	result_t beat_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= ld;
		end
	end

	always_ff @(posedge clk) begin
		if (free && ld) begin
			beat_q <= beat;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {beat_q.activation_ready, beat_q.line_ready, beat_q.length,
		beat_q.data_byte};
	assign m_tuser  = beat_q.kind;
	assign m_tlast  = beat_q.last;

endmodule

>>> hdl/uart_line_assembler_unit.sv
// Top level of the UART line assembler: control sequencer, line store and flags.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser=func, tdata=rx_byte[7:0],read_limit[15:8]
//  m_*     | out | m_tvalid/m_tready  | tuser=kind, tlast=last, tdata=data_byte,length,
//          |     |                    |   line_ready,activation_ready
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_data=activation_length (always ready)
//
// Each item is accepted and closes with a status beat; Ctrl-Z adds a second store write
// for the terminator, and a read or activation frame emits its stored bytes first.
// Stored bytes leave at one per cycle, set by the line store's single read port, unless m_tready stalls.
// One item is in work at a time; s_tready drops from acceptance until the status
// beat is loaded into the output register, which keeps it while m_tready is low.
// Reset clears position, flags and the per-entry valid bits: no clearing pass,
// an entry never written reads as zero.
`include "uart_line_assembler_unit_defines.svh"

module uart_line_assembler_unit
	import ula_pkg::*;
#(
	parameter int LINE_STORE_DEPTH = LINE_STORE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // rx_byte[7:0], read_limit[15:8]
	input  logic [1:0]           s_tuser,   // func
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // data_byte[7:0], length[13:8], line_ready, activation_ready
	output logic [1:0]           m_tuser,   // kind
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [ACT_LEN_W-1:0] cfg_data
);

	localparam int AW    = $clog2(LINE_STORE_DEPTH);
	localparam int CNT_W = $clog2(LINE_STORE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(LINE_STORE_DEPTH - 1);

	state_t                 state_q, state_d;
	logic [AW-1:0]          wp_q, wp_d;
	logic [AW-1:0]          idx_q, idx_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [LEN_W-1:0]       len_q, len_d;
	kind_t                  kind_q, kind_d;
	logic                   line_flag_q, line_flag_d;
	logic                   act_flag_q, act_flag_d;
	logic [ACT_LEN_W-1:0]   act_len_q;
	logic [LINE_STORE_DEPTH-1:0] valid_q;

	logic                   accept;
	func_t                  func;
	logic [BYTE_W-1:0]      rx_byte;
	logic [BYTE_W-1:0]      read_limit;

	// store port
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [BYTE_W-1:0]      wdata;
	logic [AW-1:0]          raddr;
	logic [BYTE_W-1:0]      rdata;
	logic [BYTE_W-1:0]      rd_byte;

	// output register
	logic                   ob_free;
	logic                   ob_ld;
	result_t                beat;
	logic                   emit_last;

	assign cfg_ready  = 1'b1;
	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign func       = func_t'(s_tuser);
	assign rx_byte    = s_tdata[7:0];
	assign read_limit = s_tdata[15:8];

	// entries never written read as zero
	assign rd_byte   = valid_q[idx_q] ? rdata : CH_NUL;
	assign emit_last = (CNT_W'(idx_q) == (cnt_q - CNT_W'(1)));

	always_comb begin
		state_d     = state_q;
		wp_d        = wp_q;
		idx_d       = idx_q;
		cnt_d       = cnt_q;
		len_d       = len_q;
		kind_d      = kind_q;
		line_flag_d = line_flag_q;
		act_flag_d  = act_flag_q;
		we          = 1'b0;
		waddr       = wp_q;
		wdata       = rx_byte;
		ob_ld       = 1'b0;
		beat        = '0;
		beat.line_ready       = line_flag_q;
		beat.activation_ready = act_flag_q;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_d   = '0;
					cnt_d   = '0;
					len_d   = '0;
					kind_d  = KIND_STATUS;
					state_d = ST_STATUS;
					case (func)
						FUNC_RX_BYTE: begin
							if (wp_q == LAST_SLOT) begin
								wp_d = '0;              // full line: byte dropped
							end else if (rx_byte == CH_CR) begin
								wp_d = wp_q;
							end else if (rx_byte == CH_CTRLZ) begin
								we          = 1'b1;
								wp_d        = wp_q + AW'(1);
								line_flag_d = 1'b1;
								state_d     = ST_ZTERM;
							end else if (rx_byte == CH_LF) begin
								we    = 1'b1;
								wdata = CH_NUL;
								if (BYTE_W'(wp_q) == BYTE_W'(act_len_q)) begin
									cnt_d      = CNT_W'(act_len_q);
									kind_d     = KIND_ACT;
									wp_d       = '0;
									act_flag_d = 1'b1;
									if (act_len_q != '0) begin
										state_d = ST_EMIT;
									end
								end else begin
									line_flag_d = 1'b1;
								end
							end else begin
								we   = 1'b1;
								wp_d = wp_q + AW'(1);
							end
						end
						FUNC_READ_LINE: begin
							if (BYTE_W'(wp_q) < read_limit) begin
								cnt_d = CNT_W'(wp_q) + CNT_W'(1);
							end else begin
								cnt_d = CNT_W'(read_limit);
							end
							len_d  = LEN_W'(cnt_d);
							kind_d = KIND_LINE;
							wp_d   = '0;
							if (cnt_d != '0) begin
								state_d = ST_EMIT;
							end
						end
						FUNC_CLR_LINE: begin
							line_flag_d = 1'b0;
						end
						FUNC_CLR_ACT: begin
							act_flag_d = 1'b0;
						end
						default: begin
							state_d = ST_STATUS;
						end
					endcase
				end
			end
			ST_ZTERM: begin
				// terminator after Ctrl-Z at the advanced position
				we      = 1'b1;
				wdata   = CH_NUL;
				state_d = ST_STATUS;
			end
			ST_EMIT: begin
				beat.kind      = kind_q;
				beat.data_byte = rd_byte;
				if (ob_free) begin
					ob_ld = 1'b1;
					if (emit_last) begin
						state_d = ST_STATUS;
					end else begin
						idx_d = idx_q + AW'(1);
					end
				end
			end
			ST_STATUS: begin
				beat.kind   = KIND_STATUS;
				beat.last   = 1'b1;
				beat.length = len_q;
				if (ob_free) begin
					ob_ld   = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// read the entry idx will hold next cycle, so rdata always matches idx_q
	assign raddr = idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			len_q       <= '0;
			kind_q      <= KIND_STATUS;
			line_flag_q <= 1'b0;
			act_flag_q  <= 1'b0;
			act_len_q   <= ACT_LEN_RESET;
			valid_q     <= '0;
		end else begin
			state_q     <= state_d;
			wp_q        <= wp_d;
			idx_q       <= idx_d;
			cnt_q       <= cnt_d;
			len_q       <= len_d;
			kind_q      <= kind_d;
			line_flag_q <= line_flag_d;
			act_flag_q  <= act_flag_d;
			if (cfg_valid && cfg_ready) begin
				act_len_q <= cfg_data;
			end
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	ula_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (LINE_STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	ula_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ob_ld),
		.beat     (beat),
		.free     (ob_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`ULA_ASSERT_NOW(a_wp_in_range, 1'b1, wp_q <= LAST_SLOT, "write position past last slot")
	`ULA_ASSERT_NOW(a_emit_idx, state_q == ST_EMIT, CNT_W'(idx_q) < cnt_q, "emit index beyond count")
	`ULA_ASSERT_NEXT(a_one_item, accept, !s_tready, "second item taken while one is in work")
	`ULA_ASSERT_NOW(a_last_is_status, m_tvalid && m_tlast, m_tuser == KIND_STATUS, "final beat is not a status")

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the UART line assembler: directed table, random line traffic.
module tb
	import ula_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = LINE_STORE_DEPTH_DEF;

	// One input beat. A directed row can instead be a register write (cfg_write, value
	// in rx_byte[4:0]) or carry a typed-in status beat (pinned) for rows whose outcome
	// is plain at a glance; byte beats ahead of it still come from the predictor.
	typedef struct packed {
		logic                cfg_write;
		func_t               func;
		logic [BYTE_W-1:0]   rx_byte;
		logic [BYTE_W-1:0]   read_limit;
		logic                pinned;
		logic [LEN_W-1:0]    pin_len;
		logic                pin_line;
		logic                pin_act;
	} line_cmd_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata   = '0;   // rx_byte[7:0], read_limit[15:8]
	logic [1:0]           s_tuser   = '0;   // func
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [15:0]          m_tdata;          // data_byte[7:0], length[13:8], line_ready, activation_ready
	logic [1:0]           m_tuser;          // kind
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [ACT_LEN_W-1:0] cfg_data  = ACT_LEN_RESET;

	uart_line_assembler_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Shadow copy of the assembler state, updated as each input beat is accepted.
	logic [BYTE_W-1:0]    shadow_store [STORE_DEPTH] = '{default: '0};
	int unsigned          shadow_pos       = 0;
	bit                   shadow_line_flag = 1'b0;
	bit                   shadow_act_flag  = 1'b0;
	int unsigned          shadow_act_len   = ACT_LEN_RESET;

	result_t     pending_beats [$];   // output beats still owed by the block, oldest first
	line_cmd_t   in_cmds [$];         // input beats waiting for the feeder
	bit          feeder_busy  = 1'b0;
	bit          send_burst   = 1'b0;
	bit          drain_burst  = 1'b0;
	int unsigned n_mismatch   = 0;
	int unsigned stim_count   = 0;
	int unsigned cur_act_len  = ACT_LEN_RESET;

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("%0t ns  mismatch on %s: got %0d, want %0d", $time, what, got, want);
		n_mismatch++;
	endtask

	function automatic void push_beat(kind_t kind, logic [BYTE_W-1:0] data, bit last,
			logic [LEN_W-1:0] len, bit lr, bit ar);
		result_t r;
		r.kind             = kind;
		r.data_byte        = data;
		r.last             = last;
		r.length           = len;
		r.line_ready       = lr;
		r.activation_ready = ar;
		pending_beats.push_back(r);
	endfunction

	// Line assembly for one accepted beat: updates the shadow state, then queues the
	// byte beats (read or activation frame) and the closing status beat. Flags in every
	// beat are the values after the step.
	function automatic void assemble_step(line_cmd_t cmd);
		int unsigned n_bytes;
		int unsigned status_len;
		kind_t       byte_kind;
		n_bytes    = 0;
		status_len = 0;
		byte_kind  = KIND_STATUS;
		case (cmd.func)
			FUNC_RX_BYTE: begin
				if (shadow_pos >= STORE_DEPTH - 1) begin
					// store full: byte is lost, position wraps
					shadow_pos = 0;
				end else if (cmd.rx_byte == CH_CR) begin
					// carriage return: no effect
				end else if (cmd.rx_byte == CH_CTRLZ) begin
					shadow_store[shadow_pos] = cmd.rx_byte;
					shadow_pos++;
					shadow_store[shadow_pos] = CH_NUL;
					shadow_line_flag = 1'b1;
				end else if (cmd.rx_byte == CH_LF) begin
					shadow_store[shadow_pos] = CH_NUL;
					if (shadow_pos == shadow_act_len) begin
						n_bytes         = shadow_act_len;
						byte_kind       = KIND_ACT;
						shadow_pos      = 0;
						shadow_act_flag = 1'b1;
					end else begin
						shadow_line_flag = 1'b1;
					end
				end else begin
					shadow_store[shadow_pos] = cmd.rx_byte;
					shadow_pos++;
				end
			end
			FUNC_READ_LINE: begin
				n_bytes = (shadow_pos < cmd.read_limit) ? shadow_pos + 1 : cmd.read_limit;
				if (n_bytes > STORE_DEPTH)
					n_bytes = STORE_DEPTH;
				byte_kind  = KIND_LINE;
				status_len = n_bytes;
				shadow_pos = 0;
			end
			FUNC_CLR_LINE: shadow_line_flag = 1'b0;
			default:       shadow_act_flag  = 1'b0;
		endcase
		for (int unsigned i = 0; i < n_bytes; i++)
			push_beat(byte_kind, shadow_store[i], 1'b0, '0, shadow_line_flag, shadow_act_flag);
		if (cmd.pinned)
			push_beat(KIND_STATUS, CH_NUL, 1'b1, cmd.pin_len, cmd.pin_line, cmd.pin_act);
		else
			push_beat(KIND_STATUS, CH_NUL, 1'b1, LEN_W'(status_len), shadow_line_flag,
				shadow_act_flag);
	endfunction

	function automatic void queue_cmd(func_t func, logic [BYTE_W-1:0] rx,
			logic [BYTE_W-1:0] lim);
		line_cmd_t cmd;
		cmd            = '0;
		cmd.func       = func;
		cmd.rx_byte    = rx;
		cmd.read_limit = lim;
		in_cmds.push_back(cmd);
		// an ignored CR does not count as traffic
		if (!(func == FUNC_RX_BYTE && rx == CH_CR))
			stim_count++;
	endfunction

	function automatic logic [BYTE_W-1:0] rnd_byte(int unsigned lo, int unsigned hi);
		return BYTE_W'($urandom_range(lo, hi));
	endfunction

	function automatic logic [BYTE_W-1:0] plain_char();
		logic [BYTE_W-1:0] c;
		do begin
			c = ($urandom_range(0, 3) == 0) ? rnd_byte(0, 255) : rnd_byte(32, 126);
		end while (c == CH_CR || c == CH_LF || c == CH_CTRLZ);
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] any_limit();
		case ($urandom_range(0, 3))
			0:       return rnd_byte(0, 255);
			1:       return 8'd255;
			default: return rnd_byte(0, 34);
		endcase
	endfunction

	// Read to clear the position, a line of plain bytes (sometimes exactly the activation
	// length, so a newline raises a frame), mostly a terminator, often a read, at times flag clears.
	function automatic void line_run();
		int unsigned n;
		int unsigned tail;
		queue_cmd(FUNC_READ_LINE, rnd_byte(0, 255), any_limit());
		n = ($urandom_range(0, 2) == 0) ? cur_act_len : $urandom_range(0, 24);
		if (n > STORE_DEPTH - 2)
			n = STORE_DEPTH - 2;
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0)
				queue_cmd(FUNC_RX_BYTE, CH_CR, rnd_byte(0, 255));
			queue_cmd(FUNC_RX_BYTE, plain_char(), rnd_byte(0, 255));
		end
		tail = $urandom_range(0, 7);
		if (tail == 0)
			queue_cmd(FUNC_RX_BYTE, CH_CTRLZ, rnd_byte(0, 255));
		else if (tail != 1)
			queue_cmd(FUNC_RX_BYTE, CH_LF, rnd_byte(0, 255));
		if ($urandom_range(0, 2) != 0)
			queue_cmd(FUNC_READ_LINE, rnd_byte(0, 255), any_limit());
		if ($urandom_range(0, 3) == 0)
			queue_cmd(FUNC_CLR_LINE, rnd_byte(0, 255), rnd_byte(0, 255));
		if ($urandom_range(0, 3) == 0)
			queue_cmd(FUNC_CLR_ACT, rnd_byte(0, 255), rnd_byte(0, 255));
	endfunction

	// Fill the store to the last slot; then either read everything (longest burst) or
	// push a byte that gets dropped and check the wrap.
	function automatic void overflow_run(bit full_read);
		logic [BYTE_W-1:0] lost;
		queue_cmd(FUNC_READ_LINE, rnd_byte(0, 255), rnd_byte(0, 255));
		for (int i = 0; i < STORE_DEPTH - 1; i++)
			queue_cmd(FUNC_RX_BYTE, plain_char(), rnd_byte(0, 255));
		if (full_read) begin
			queue_cmd(FUNC_READ_LINE, rnd_byte(0, 255), 8'd255);
		end else begin
			case ($urandom_range(0, 3))
				0:       lost = CH_CR;
				1:       lost = CH_LF;
				2:       lost = CH_CTRLZ;
				default: lost = rnd_byte(0, 255);
			endcase
			queue_cmd(FUNC_RX_BYTE, lost, rnd_byte(0, 255));
			queue_cmd(FUNC_RX_BYTE, plain_char(), rnd_byte(0, 255));
			queue_cmd(FUNC_READ_LINE, rnd_byte(0, 255), rnd_byte(0, 8));
		end
	endfunction

	function automatic void noise_run();
		int unsigned n;
		n = $urandom_range(1, 6);
		for (int unsigned i = 0; i < n; i++)
			queue_cmd(func_t'($urandom_range(0, 3)), rnd_byte(0, 255), rnd_byte(0, 255));
	endfunction

	// Block is idle once the feeder is empty and every owed beat has arrived; every
	// step ends in a status beat.
	task automatic wait_idle();
		while (in_cmds.size() != 0 || feeder_busy || pending_beats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_act_len(logic [ACT_LEN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid      <= 1'b0;
		shadow_act_len = value;
		cur_act_len    = value;
	endtask

	// Directed rows: reset state, flag clears, CR, Ctrl-Z, newline, reads with zero and
	// full limits, read of the slot at the position, activation at the shortest non-empty length,
	// the longest length that no newline can reach.
	line_cmd_t directed [23] = '{
		'{1'b0, FUNC_READ_LINE, 8'h00, 8'd0,   1'b1, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_READ_LINE, 8'h00, 8'd255, 1'b1, 6'd1, 1'b0, 1'b0},
		'{1'b0, FUNC_CLR_LINE,  8'h00, 8'd0,   1'b1, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_CLR_ACT,   8'h00, 8'd0,   1'b1, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_RX_BYTE,   8'h41, 8'd0,   1'b0, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_RX_BYTE,   CH_CR, 8'd0,   1'b0, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_RX_BYTE,   8'hFF, 8'hFF,  1'b0, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_RX_BYTE,   8'h00, 8'd0,   1'b0, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_RX_BYTE, CH_CTRLZ, 8'd0,  1'b1, 6'd0, 1'b1, 1'b0},
		'{1'b0, FUNC_RX_BYTE,   CH_LF, 8'd0,   1'b0, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_READ_LINE, 8'h00, 8'd2,   1'b0, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_READ_LINE, 8'hFF, 8'd255, 1'b0, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_RX_BYTE,   8'h42, 8'd0,   1'b0, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_READ_LINE, 8'h00, 8'd255, 1'b0, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_CLR_LINE,  8'h00, 8'd0,   1'b1, 6'd0, 1'b0, 1'b0},
		'{1'b1, FUNC_RX_BYTE,   8'd1,  8'd0,   1'b0, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_RX_BYTE,   8'h55, 8'd0,   1'b0, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_RX_BYTE,   CH_LF, 8'd0,   1'b0, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_CLR_ACT,   8'h00, 8'd0,   1'b1, 6'd0, 1'b0, 1'b0},
		'{1'b1, FUNC_RX_BYTE,   8'd31, 8'd0,   1'b0, 6'd0, 1'b0, 1'b0},
		'{1'b0, FUNC_RX_BYTE,   CH_LF, 8'd0,   1'b1, 6'd0, 1'b1, 1'b0},
		'{1'b0, FUNC_READ_LINE, 8'h00, 8'd1,   1'b0, 6'd0, 1'b0, 1'b0},
		'{1'b1, FUNC_RX_BYTE,   8'd14, 8'd0,   1'b0, 6'd0, 1'b0, 1'b0}
	};

	// Feeder: one input beat at a time, a random hold-off in front of each (none while
	// in a burst). Prediction happens at the accepting edge, so order matches the DUT.
	initial begin : feeder
		line_cmd_t   cmd;
		int unsigned gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (in_cmds.size() == 0) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end else begin
				cmd         = in_cmds.pop_front();
				feeder_busy = 1'b1;
				if ($urandom_range(0, 39) == 0)
					send_burst = !send_burst;
				gap = send_burst ? 0 : $urandom_range(0, 14);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				s_tvalid <= 1'b1;
				s_tdata  <= {cmd.read_limit, cmd.rx_byte};
				s_tuser  <= cmd.func;
				do @(posedge clk); while (!s_tready);
				assemble_step(cmd);
				feeder_busy = 1'b0;
			end
		end
	end

	// Sink: random stalls on m_tready, each accepted beat checked field by field
	// against the oldest owed beat.
	initial begin : sink
		int unsigned stall;
		result_t     want;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				drain_burst = !drain_burst;
			stall = drain_burst ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_beats.size() == 0) begin
				report_mismatch("beat with nothing owed (tdata)", m_tdata, 0);
			end else begin
				want = pending_beats.pop_front();
				if (m_tuser != want.kind)
					report_mismatch("kind", m_tuser, want.kind);
				if (m_tdata[7:0] != want.data_byte)
					report_mismatch("data_byte", m_tdata[7:0], want.data_byte);
				if (m_tlast != want.last)
					report_mismatch("last", m_tlast, want.last);
				if (m_tdata[13:8] != want.length)
					report_mismatch("length", m_tdata[13:8], want.length);
				if (m_tdata[14] != want.line_ready)
					report_mismatch("line_ready", m_tdata[14], want.line_ready);
				if (m_tdata[15] != want.activation_ready)
					report_mismatch("activation_ready", m_tdata[15], want.activation_ready);
			end
		end
	end

	// Main sequence: reset, directed table, then random phases at several activation
	// lengths (reset value, shortest non-empty and longest, a mid value, a random one).
	initial begin : stimulus
		int unsigned act_plan [5];
		int unsigned target;
		act_plan = '{14, 1, 31, 9, 0};
		act_plan[4] = $urandom_range(2, 30);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].cfg_write) begin
				wait_idle();
				write_act_len(directed[i].rx_byte[ACT_LEN_W-1:0]);
			end else begin
				in_cmds.push_back(directed[i]);
			end
		end

		for (int p = 0; p < 5; p++) begin
			wait_idle();
			write_act_len(ACT_LEN_W'(act_plan[p]));
			if (p == 0) begin
				overflow_run(1'b1);
				overflow_run(1'b0);
			end
			target = stim_count + 30;
			while (stim_count < target) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: line_run();
					5:             overflow_run($urandom_range(0, 1));
					6, 7:          noise_run();
					default: begin
						line_run();
						noise_run();
					end
				endcase
			end
		end

		wait_idle();
		// longest step is a full read: 32 bytes plus status
		repeat (40) @(posedge clk);
		if (n_mismatch == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Hang guard, several times the slowest legal run.
	initial begin : watchdog
		#6_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
